// ===== design/assert_macros.svh =====
// assertion macros for the percent identity block
// clocked implication checks, disabled while reset is active
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ALPI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ALPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/alpi_pkg.sv =====
// shared types, constants and helpers for the percent identity block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package alpi_pkg;

	localparam int MAX_COLUMNS = 65536;
	localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);

	// result field widths
	localparam int WHOLE_W = 7;
	localparam int Q8_W    = 15;
	localparam int TOTAL_W = 17;

	// rounding scales: twice 100 and twice 25600
	localparam int WHOLE_SCALE = 200;
	localparam int Q8_SCALE    = 51200;
	localparam int NUM_W       = 32;
	localparam int DEN_W       = CNT_W + 1;
	localparam int DSH_W       = DEN_W + Q8_W;

	// register map
	localparam int PADDR_W = 3;
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_SKIP = 1'b1;
	localparam int SKIP_W = 16;

	// queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// characters
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_A       = 8'h41;
	localparam logic [7:0] CH_C       = 8'h43;
	localparam logic [7:0] CH_G       = 8'h47;
	localparam logic [7:0] CH_T       = 8'h54;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_Z   = 8'h7A;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	typedef struct packed {
		logic [CNT_W-1:0] aligned;
		logic [CNT_W-1:0] matched;
	} counts_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
			r = c - CASE_DELTA;
		end
		return r;
	endfunction

	function automatic logic is_nucleotide(input logic [7:0] c);
		logic [7:0] u;
		u = fold_upper(c);
		return (u == CH_A) || (u == CH_C) || (u == CH_G) || (u == CH_T);
	endfunction

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v < CNT_W'(MAX_COLUMNS)) begin
			r = v + CNT_W'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/alpi_front.sv =====
// front end: classifies each column and keeps the running counts
// depends on alpi_pkg; hands finished count pairs to the queue
`timescale 1ns / 1ps
`default_nettype none

module alpi_front
	import alpi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        char_a,
	input  wire logic [7:0]        char_b,
	input  wire logic              last_column,
	input  wire logic              identity_mode,
	input  wire logic [SKIP_W-1:0] skip_columns,
	output logic                   push,
	output counts_t                push_data
);

	logic [CNT_W-1:0] aligned_q;
	logic [CNT_W-1:0] matched_q;
	logic [CNT_W-1:0] column_q;
	logic             counting;
	logic             aligned;
	logic             matched;
	logic [CNT_W-1:0] aligned_nx;
	logic [CNT_W-1:0] matched_nx;

	always_comb begin
		counting = column_q >= CNT_W'(skip_columns);
		if (identity_mode) begin
			aligned = is_nucleotide(char_a) && is_nucleotide(char_b);
		end else begin
			aligned = (char_a != CH_DASH) && (char_b != CH_DASH);
		end
		matched    = fold_upper(char_a) == fold_upper(char_b);
		aligned_nx = (counting && aligned) ? bump(aligned_q) : aligned_q;
		matched_nx = (counting && aligned && matched) ? bump(matched_q) : matched_q;
	end

	assign push              = accept && last_column;
	assign push_data.aligned = aligned_nx;
	assign push_data.matched = matched_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aligned_q <= '0;
			matched_q <= '0;
			column_q  <= '0;
		end else if (accept) begin
			if (last_column) begin
				aligned_q <= '0;
				matched_q <= '0;
				column_q  <= '0;
			end else begin
				aligned_q <= aligned_nx;
				matched_q <= matched_nx;
				column_q  <= bump(column_q);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/alpi_fifo.sv =====
// short queue of finished count pairs between front and back
// depends on alpi_pkg
`timescale 1ns / 1ps
`default_nettype none

module alpi_fifo
	import alpi_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  counts_t   push_data,
	input  wire logic pop,
	output counts_t   pop_data,
	output fifo_stat_t stat
);

	counts_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [FIFO_CW-1:0]   fill_q;
	logic                 do_push;
	logic                 do_pop;

	assign stat.full  = fill_q == FIFO_CW'(FIFO_DEPTH);
	assign stat.empty = fill_q == '0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + FIFO_AW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + FIFO_CW'(1);
				2'b01:   fill_q <= fill_q - FIFO_CW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/alpi_back.sv =====
// back end: rounds the identity by restoring division, one quotient bit a cycle
// depends on alpi_pkg; takes count pairs from the queue, holds the result register
`timescale 1ns / 1ps
`default_nettype none

module alpi_back
	import alpi_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  fifo_stat_t            stat,
	input  counts_t               pop_data,
	output logic                  pop,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output logic [WHOLE_W-1:0]    percent_whole,
	output logic [Q8_W-1:0]       percent_q8,
	output logic [TOTAL_W-1:0]    aligned_total,
	output logic [TOTAL_W-1:0]    match_total,
	output logic                  none_aligned
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DQ8  = 3'd2;
	localparam logic [2:0] ST_DW   = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] al_q;
	logic [CNT_W-1:0] ma_q;
	logic [NUM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [Q8_W-1:0]  quo_q;
	logic [Q8_W-1:0]  q8_q;
	logic [3:0]       step_q;

	logic [DEN_W-1:0] den;
	logic             take;
	logic [NUM_W-1:0] rem_nx;
	logic [Q8_W-1:0]  quo_nx;

	always_comb begin
		den    = {al_q, 1'b0};
		take   = {{(DSH_W - NUM_W){1'b0}}, rem_q} >= dsh_q;
		rem_nx = take ? rem_q - dsh_q[NUM_W-1:0] : rem_q;
		quo_nx = {quo_q[Q8_W-2:0], take};
	end

	assign pop       = (state_q == ST_IDLE) && !stat.empty;
	assign out_valid = state_q == ST_DONE;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				al_q <= pop_data.aligned;
				ma_q <= pop_data.matched;
			end
			ST_PREP: begin
				// numerator ma*51200 + al over 2*al gives the q8 percent rounded half up
				rem_q  <= NUM_W'(NUM_W'(ma_q) * NUM_W'(Q8_SCALE)) + NUM_W'(al_q);
				dsh_q  <= DSH_W'({den, {(Q8_W - 1){1'b0}}});
				quo_q  <= '0;
				step_q <= 4'(Q8_W - 1);
				if (al_q == '0) begin
					percent_whole <= '0;
					percent_q8    <= '0;
					aligned_total <= '0;
					match_total   <= '0;
					none_aligned  <= 1'b1;
				end
			end
			ST_DQ8: begin
				rem_q  <= rem_nx;
				dsh_q  <= dsh_q >> 1;
				quo_q  <= quo_nx;
				step_q <= step_q - 4'd1;
				if (step_q == '0) begin
					q8_q   <= quo_nx;
					rem_q  <= NUM_W'(NUM_W'(ma_q) * NUM_W'(WHOLE_SCALE)) + NUM_W'(al_q);
					dsh_q  <= DSH_W'({den, {(WHOLE_W - 1){1'b0}}});
					quo_q  <= '0;
					step_q <= 4'(WHOLE_W - 1);
				end
			end
			ST_DW: begin
				rem_q  <= rem_nx;
				dsh_q  <= dsh_q >> 1;
				quo_q  <= quo_nx;
				step_q <= step_q - 4'd1;
				if (step_q == '0) begin
					percent_whole <= quo_nx[WHOLE_W-1:0];
					percent_q8    <= q8_q;
					aligned_total <= TOTAL_W'(al_q);
					match_total   <= TOTAL_W'(ma_q);
					none_aligned  <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (!stat.empty) begin
					state_q <= ST_PREP;
				end
				ST_PREP: state_q <= (al_q == '0) ? ST_DONE : ST_DQ8;
				ST_DQ8:  if (step_q == '0) begin
					state_q <= ST_DW;
				end
				ST_DW:   if (step_q == '0) begin
					state_q <= ST_DONE;
				end
				ST_DONE: if (!out_stall) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/alignment_percent_identity.sv =====
// top level of the percent identity block: register port, front, queue, back
// depends on alpi_pkg, alpi_front, alpi_fifo, alpi_back and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Takes one alignment column per cycle (char_a, char_b, last_column) and, after
// the column marked last, gives one result with the aligned and matching counts
// and the identity rounded half up to a whole percent and to Q8. Columns stream
// in at one per cycle unless in_stall holds them; the front counters never hold
// the input on their own. Back end per result: queue pop, set-up, then, if any
// column aligned, 15 quotient steps for Q8 and 7 for the whole percent on the
// shared one-bit-a-cycle divider, then the output register. Two finished
// alignments can wait in the queue; in_stall holds the input while it is full
// (short alignments in a run, or a stalled receiver). Registers: identity_mode
// at 0x0 (0 gap test, 1 ACGT test), skip_columns at 0x4. Write them while idle.

module alignment_percent_identity
	import alpi_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         char_a,
	input  wire logic [7:0]         char_b,
	input  wire logic               last_column,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [WHOLE_W-1:0]      percent_whole,
	output logic [Q8_W-1:0]         percent_q8,
	output logic [TOTAL_W-1:0]      aligned_total,
	output logic [TOTAL_W-1:0]      match_total,
	output logic                    none_aligned
);

	logic              mode_q;
	logic [SKIP_W-1:0] skip_q;
	logic              wr_en;
	logic              in_accept;
	logic              push;
	logic              pop;
	counts_t           push_data;
	counts_t           pop_data;
	fifo_stat_t        stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			skip_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MODE: mode_q <= pwdata[0];
				REG_SKIP: skip_q <= pwdata[SKIP_W-1:0];
				default:  mode_q <= mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = {31'd0, mode_q};
			REG_SKIP: prdata = {{(32 - SKIP_W){1'b0}}, skip_q};
			default:  prdata = '0;
		endcase
	end

	// hold requests while no queue slot is free for a finished alignment
	assign in_stall  = stat.full;
	assign in_accept = in_valid && !in_stall;

	alpi_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_accept),
		.char_a        (char_a),
		.char_b        (char_b),
		.last_column   (last_column),
		.identity_mode (mode_q),
		.skip_columns  (skip_q),
		.push          (push),
		.push_data     (push_data)
	);

	alpi_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (stat)
	);

	alpi_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.stat          (stat),
		.pop_data      (pop_data),
		.pop           (pop),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.percent_whole (percent_whole),
		.percent_q8    (percent_q8),
		.aligned_total (aligned_total),
		.match_total   (match_total),
		.none_aligned  (none_aligned)
	);

	`ALPI_ASSERT_NOW(a_none_zero, clk, arst_n, out_valid && none_aligned, percent_whole == '0 && percent_q8 == '0 && aligned_total == '0 && match_total == '0, "empty alignment gave nonzero result")
	`ALPI_ASSERT_NOW(a_ratio_range, clk, arst_n, out_valid && !none_aligned, match_total <= aligned_total && aligned_total != '0 && percent_whole <= WHOLE_W'(100) && percent_q8 <= Q8_W'(25600), "identity out of range")
	`ALPI_ASSERT_NEXT(a_last_pushes, clk, arst_n, in_accept && last_column, !stat.empty || pop, "finished alignment missing from queue")

endmodule

`default_nettype wire

// ===== dv/alignment_percent_identity_tb.sv =====
// self-checking bench for the alignment percent identity block
// relies on alpi_pkg and alignment_percent_identity; drives columns and registers, scores results
`timescale 1ns / 1ps

module alignment_percent_identity_tb;
	import alpi_pkg::*;

	typedef struct packed {
		bit [WHOLE_W-1:0] whole;
		bit [Q8_W-1:0]    q8;
		bit [TOTAL_W-1:0] aligned;
		bit [TOTAL_W-1:0] matched;
		bit               none;
	} identity_t;

	typedef struct packed {
		bit        cfg;
		bit [31:0] mode_word;
		bit [31:0] skip_word;
		bit [7:0]  a;
		bit [7:0]  b;
		bit        last;
		bit        typed;
		identity_t res;
	} column_row_t;

	localparam logic [PADDR_W-1:0] ADDR_MODE = {REG_MODE, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_SKIP = {REG_SKIP, 2'b00};
	localparam bit [31:0] MODE_GAP  = 32'd0;
	localparam bit [31:0] MODE_BASE = 32'd1;

	localparam int HOLD_LEN     = 300;
	localparam int DRAIN_CYCLES = 64;
	// covers the long receiver hold plus divider time with plenty of margin
	localparam int QUIET_LIMIT  = 5000;

	localparam identity_t RES_NONE     = '{0, 0, 0, 0, 1'b1};
	localparam identity_t RES_FULL_ONE = '{100, 25600, 1, 1, 1'b0};
	localparam identity_t RES_MISS_ONE = '{0, 0, 1, 0, 1'b0};
	localparam identity_t RES_HALF     = '{50, 12800, 2, 1, 1'b0};

	localparam column_row_t DIRECTED_ROWS [23] = '{
		'{1'b1, MODE_GAP, 32'd0, "A", "A", 1'b1, 1'b1, RES_FULL_ONE},
		'{1'b0, MODE_GAP, 32'd0, "-", "A", 1'b1, 1'b1, RES_NONE},
		'{1'b0, MODE_GAP, 32'd0, 8'h00, 8'hFF, 1'b1, 1'b1, RES_MISS_ONE},
		'{1'b0, MODE_GAP, 32'd0, 8'hFF, 8'hFF, 1'b1, 1'b1, RES_FULL_ONE},
		'{1'b0, MODE_GAP, 32'd0, "a", "A", 1'b0, 1'b0, RES_NONE},
		'{1'b0, MODE_GAP, 32'd0, "x", "y", 1'b0, 1'b0, RES_NONE},
		'{1'b0, MODE_GAP, 32'd0, "G", "-", 1'b1, 1'b1, RES_HALF},
		'{1'b0, MODE_GAP, 32'd0, "z", "Z", 1'b0, 1'b0, RES_NONE},
		// just outside the lower-case range on either side
		'{1'b0, MODE_GAP, 32'd0, 8'h7B, 8'h5B, 1'b0, 1'b0, RES_NONE},
		'{1'b0, MODE_GAP, 32'd0, 8'h60, 8'h40, 1'b0, 1'b0, RES_NONE},
		'{1'b0, MODE_GAP, 32'd0, "c", "c", 1'b1, 1'b0, RES_NONE},
		'{1'b1, MODE_BASE, 32'd0, "A", "a", 1'b0, 1'b0, RES_NONE},
		'{1'b0, MODE_BASE, 32'd0, "N", "A", 1'b0, 1'b0, RES_NONE},
		'{1'b0, MODE_BASE, 32'd0, "t", "T", 1'b0, 1'b0, RES_NONE},
		'{1'b0, MODE_BASE, 32'd0, "g", "c", 1'b1, 1'b0, RES_NONE},
		'{1'b0, MODE_BASE, 32'd0, 8'h00, 8'h00, 1'b1, 1'b1, RES_NONE},
		'{1'b0, MODE_BASE, 32'd0, "-", "-", 1'b1, 1'b1, RES_NONE},
		'{1'b1, MODE_GAP, 32'd2, "A", "A", 1'b0, 1'b0, RES_NONE},
		'{1'b0, MODE_GAP, 32'd2, "C", "C", 1'b0, 1'b0, RES_NONE},
		'{1'b0, MODE_GAP, 32'd2, "G", "T", 1'b1, 1'b1, RES_MISS_ONE},
		// last column still inside the skipped range
		'{1'b0, MODE_GAP, 32'd2, "A", "A", 1'b1, 1'b1, RES_NONE},
		// upper register bits must be ignored
		'{1'b1, 32'hDEAD_BEEF, 32'hABCD_0001, "T", "T", 1'b0, 1'b0, RES_NONE},
		'{1'b0, 32'hDEAD_BEEF, 32'hABCD_0001, "a", "A", 1'b1, 1'b1, RES_FULL_ONE}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         char_a = '0;
	logic [7:0]         char_b = '0;
	logic               last_column = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [WHOLE_W-1:0] percent_whole;
	logic [Q8_W-1:0]    percent_q8;
	logic [TOTAL_W-1:0] aligned_total;
	logic [TOTAL_W-1:0] match_total;
	logic               none_aligned;

	// predictor state and register copies
	bit               cfg_base_mode;
	bit [SKIP_W-1:0]  cfg_skip;
	bit [TOTAL_W-1:0] tally_aligned;
	bit [TOTAL_W-1:0] tally_match;
	bit [TOTAL_W-1:0] col_pos;

	identity_t expected_identity [$];
	int        mismatch_count;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        hold_token;
	int        hold_seen;
	int        hold_left;
	int        quiet_cycles;

	alignment_percent_identity dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_a        (char_a),
		.char_b        (char_b),
		.last_column   (last_column),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.percent_whole (percent_whole),
		.percent_q8    (percent_q8),
		.aligned_total (aligned_total),
		.match_total   (match_total),
		.none_aligned  (none_aligned)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit [7:0] upcase_byte(input bit [7:0] c);
		return (c >= "a" && c <= "z") ? (c ^ 8'h20) : c;
	endfunction

	function automatic bit is_base(input bit [7:0] c);
		case (upcase_byte(c))
			"A", "C", "G", "T": return 1'b1;
			default:            return 1'b0;
		endcase
	endfunction

	function automatic bit [TOTAL_W-1:0] sat_inc(input bit [TOTAL_W-1:0] v);
		return (v < MAX_COLUMNS) ? v + 1'b1 : v;
	endfunction

	// advances the tallies by one column; returns 1 when the column closes an alignment
	function automatic bit score_column(input bit [7:0] a, input bit [7:0] b, input bit last,
		output identity_t res);
		bit              counted;
		longint unsigned al;
		longint unsigned ma;
		res = RES_NONE;
		if (col_pos >= cfg_skip) begin
			counted = cfg_base_mode ? (is_base(a) && is_base(b)) : (a != CH_DASH && b != CH_DASH);
			if (counted) begin
				tally_aligned = sat_inc(tally_aligned);
				if (upcase_byte(a) == upcase_byte(b)) begin
					tally_match = sat_inc(tally_match);
				end
			end
		end
		col_pos = sat_inc(col_pos);
		if (!last) begin
			return 1'b0;
		end
		al = tally_aligned;
		ma = tally_match;
		res.aligned = tally_aligned;
		res.matched = tally_match;
		if (al != 0) begin
			// half-up rounding done as (2*m*scale + a) / (2*a)
			res.whole = WHOLE_W'((ma * 200 + al) / (2 * al));
			res.q8    = Q8_W'((ma * 51200 + al) / (2 * al));
			res.none  = 1'b0;
		end
		tally_aligned = '0;
		tally_match   = '0;
		col_pos       = '0;
		return 1'b1;
	endfunction

	function automatic bit [7:0] pick_char();
		case ($urandom_range(9))
			0: return "A";
			1: return "C";
			2: return "G";
			3: return "T";
			4: return "a";
			5: return "t";
			6: return CH_DASH;
			7: return 8'($urandom_range("a", "z"));
			default: return 8'($urandom);
		endcase
	endfunction

	// same letter as a, with its case flipped now and then
	function automatic bit [7:0] mirror_char(input bit [7:0] a);
		if ((a | 8'h20) >= "a" && (a | 8'h20) <= "z" && $urandom_range(1)) begin
			return a ^ 8'h20;
		end
		return a;
	endfunction

	function automatic void compare_field(input string label, input logic [TOTAL_W-1:0] want,
		input logic [TOTAL_W-1:0] got);
		if (got !== want) begin
			$display("%0t %s expected %0d actual %0d", $time, label, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic check_identity();
		identity_t want;
		if (expected_identity.size() == 0) begin
			$display("%0t result with none expected: whole %0d aligned %0d match %0d",
				$time, percent_whole, aligned_total, match_total);
			mismatch_count++;
		end else begin
			want = expected_identity.pop_front();
			compare_field("percent_whole", want.whole, percent_whole);
			compare_field("percent_q8", want.q8, percent_q8);
			compare_field("aligned_total", want.aligned, aligned_total);
			compare_field("match_total", want.matched, match_total);
			compare_field("none_aligned", want.none, none_aligned);
		end
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_MODE) begin
			cfg_base_mode = data[0];
		end else if (addr == ADDR_SKIP) begin
			cfg_skip = data[SKIP_W-1:0];
		end
		@(posedge clk);
	endtask

	// stop offering and let every outstanding result come back
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_identity.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input bit [31:0] mode_word, input bit [31:0] skip_word);
		settle();
		write_reg(ADDR_MODE, mode_word);
		write_reg(ADDR_SKIP, skip_word);
	endtask

	task automatic configure_random();
		bit [15:0] skip;
		case ($urandom_range(3))
			0: skip = 16'd0;
			1: skip = 16'($urandom_range(1, 6));
			2: skip = 16'd40;
			default: skip = 16'($urandom_range(20));
		endcase
		configure($urandom, {16'($urandom), skip});
	endtask

	task automatic offer_column(input bit [7:0] a, input bit [7:0] b, input bit last,
		input bit typed, input identity_t typed_res);
		identity_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		char_a      <= a;
		char_b      <= b;
		last_column <= last;
		do @(posedge clk); while (in_stall);
		if (score_column(a, b, last, res)) begin
			expected_identity.push_back(typed ? typed_res : res);
		end
	endtask

	// mostly well-formed alignments with random content, some stray columns
	task automatic run_alignments(input int n_items);
		int      sent;
		int      len;
		bit      open_run;
		bit      last;
		bit [7:0] a;
		bit [7:0] b;
		sent = 0;
		open_run = 1'b0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				last = ($urandom_range(7) == 0);
				offer_column(8'($urandom), 8'($urandom), last, 1'b0, RES_NONE);
				open_run = !last;
				sent++;
			end else begin
				len = ($urandom_range(7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
				for (int k = 0; k < len; k++) begin
					a = pick_char();
					b = ($urandom_range(4) < 3) ? mirror_char(a) : pick_char();
					offer_column(a, b, k == len - 1, 1'b0, RES_NONE);
				end
				open_run = 1'b0;
				sent += len;
			end
		end
		if (open_run) begin
			offer_column(pick_char(), pick_char(), 1'b1, 1'b0, RES_NONE);
		end
	endtask

	// receiver: scores each result, stalls at random or for a long hold when asked
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			check_identity();
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_LEN - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t no request or result moved for %0d cycles", $time, QUIET_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 15;
		recv_idle_pct = 68;
		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].cfg) begin
				configure(DIRECTED_ROWS[i].mode_word, DIRECTED_ROWS[i].skip_word);
			end
			offer_column(DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].last,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
		end
		configure_random();
		run_alignments(110);

		send_idle_pct = 68;
		recv_idle_pct = 15;
		configure_random();
		run_alignments(110);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure_random();
		// one-column alignments against a held-off receiver back up into in_stall
		hold_token <= hold_token + 1;
		repeat (40) begin
			offer_column(pick_char(), pick_char(), 1'b1, 1'b0, RES_NONE);
		end
		run_alignments(100);

		// widest skip: every column falls inside the skipped range
		configure(MODE_GAP, 32'h0000_FFFF);
		for (int k = 0; k < 6; k++) begin
			offer_column(pick_char(), pick_char(), k == 5, 1'b0, RES_NONE);
		end
		// upper register bits set, base test with mismatches then matches
		configure(32'hFFFF_FFFF, 32'hFFFF_0000);
		for (int k = 0; k < 12; k++) begin
			if (k < 4) begin
				offer_column("A", "C", 1'b0, 1'b0, RES_NONE);
			end else begin
				offer_column("G", "g", k == 11, 1'b0, RES_NONE);
			end
		end

		settle();
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== alignment_percent_identity.f =====
+incdir+design
design/alpi_pkg.sv
design/alpi_front.sv
design/alpi_fifo.sv
design/alpi_back.sv
design/alignment_percent_identity.sv
dv/alignment_percent_identity_tb.sv
